// ----- rtl/vrp_pkg.sv -----
// Package for the vertex rotate/project pipeline: beat types, register codes, fixed-point helpers.
`default_nettype none
package vrp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DIV_STAGES = 32;  // one quotient bit per stage
  localparam logic signed [32:0] ONE_Q   = 33'sd1 <<< FRAC_BITS;
  localparam logic signed [32:0] THREE_Q = 33'sd3 <<< FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               depth_zero;
    logic               saturated;
  } out_beat_t;

  typedef enum logic [2:0] {
    CFG_COS_Z    = 3'd0,
    CFG_SIN_Z    = 3'd1,
    CFG_COS_X    = 3'd2,
    CFG_SIN_X    = 3'd3,
    CFG_PROJ_X   = 3'd4,
    CFG_PROJ_Y   = 3'd5,
    CFG_SCREEN_W = 3'd6,
    CFG_SCREEN_H = 3'd7
  } cfg_reg_t;

  // {clamped, value} clamped to the 32-bit signed range
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // drop fraction bits, round half up, then clamp
  function automatic logic [32:0] rnd_sat(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return sat32(r);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/vertex_rotate_project_unit.sv -----
// Top level: fully pipelined vertex rotation, perspective divide and viewport mapping.
`default_nettype none
// One vertex can be started every clock cycle (busy is a registered copy of reset, so it is
// only high during reset and until that register clears); each result is strobed for
// a single cycle on out_strobe; the receiver cannot stall, so results must be taken as they
// come. The pipeline holds the perspective divide, a 32-stage restoring divider producing
// one quotient bit per stage, plus four multiply/round stages for the two rotations, one for
// depth and the projection products, one divider setup stage, one stage to sign and clamp the
// quotient and two stages for the viewport mapping.
// Configuration registers are read live by the stages that use them, so write them only
// while the pipe is empty. A zero depth skips the divide and raises depth_zero; any clamp
// on the way raises saturated.
module vertex_rotate_project_unit
  import vrp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output      logic      busy,
  input  wire in_beat_t  in_beat,
  output      logic      out_strobe,
  output      out_beat_t out_beat,
  input  wire logic      cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [24:0] cfg_wdata
);

  // ---------------- configuration ----------------
  logic signed [17:0] cos_z_r, sin_z_r, cos_x_r, sin_x_r;
  logic [24:0] proj_x_r, proj_y_r;
  logic [12:0] scr_w_r, scr_h_r;
  logic        busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_z_r  <= 18'sd65536;
      sin_z_r  <= '0;
      cos_x_r  <= 18'sd65536;
      sin_x_r  <= '0;
      proj_x_r <= 25'd49152;
      proj_y_r <= 25'd65536;
      scr_w_r  <= 13'd640;
      scr_h_r  <= 13'd480;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_COS_Z:    cos_z_r  <= cfg_wdata[17:0];
        CFG_SIN_Z:    sin_z_r  <= cfg_wdata[17:0];
        CFG_COS_X:    cos_x_r  <= cfg_wdata[17:0];
        CFG_SIN_X:    sin_x_r  <= cfg_wdata[17:0];
        CFG_PROJ_X:   proj_x_r <= cfg_wdata;
        CFG_PROJ_Y:   proj_y_r <= cfg_wdata;
        CFG_SCREEN_W: scr_w_r  <= cfg_wdata[12:0];
        CFG_SCREEN_H: scr_h_r  <= cfg_wdata[12:0];
      endcase
    end
  end

  // busy is a registered copy of reset; the pipe itself never refuses a beat
  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end
  assign busy = busy_r;

  logic in_accept;
  assign in_accept = start && !busy_r;

  // ---------------- stage a: Z rotation products ----------------
  logic               a_vld_r;
  logic signed [49:0] a_xc_r, a_ys_r, a_xs_r, a_yc_r;
  logic signed [31:0] a_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else        a_vld_r <= in_accept;
  end
  always_ff @(posedge clk) begin
    a_xc_r <= in_beat.vertex_x * cos_z_r;
    a_ys_r <= in_beat.vertex_y * sin_z_r;
    a_xs_r <= in_beat.vertex_x * sin_z_r;
    a_yc_r <= in_beat.vertex_y * cos_z_r;
    a_z_r  <= in_beat.vertex_z;
  end

  // ---------------- stage b: Z rotation round/clamp ----------------
  logic               b_vld_r, b_sat_r;
  logic signed [31:0] b_xz_r, b_yz_r, b_z_r;
  logic signed [50:0] b_sx, b_sy;
  logic [32:0]        b_rx, b_ry;

  always_comb begin
    b_sx = 51'(a_xc_r) - 51'(a_ys_r);
    b_sy = 51'(a_xs_r) + 51'(a_yc_r);
    b_rx = rnd_sat(64'(b_sx));
    b_ry = rnd_sat(64'(b_sy));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else        b_vld_r <= a_vld_r;
  end
  always_ff @(posedge clk) begin
    b_xz_r  <= b_rx[31:0];
    b_yz_r  <= b_ry[31:0];
    b_z_r   <= a_z_r;
    b_sat_r <= b_rx[32] | b_ry[32];
  end

  // ---------------- stage c: X rotation products ----------------
  logic               c_vld_r, c_sat_r;
  logic signed [49:0] c_yc_r, c_zs_r, c_ys_r, c_zc_r;
  logic signed [31:0] c_xz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else        c_vld_r <= b_vld_r;
  end
  always_ff @(posedge clk) begin
    c_yc_r  <= b_yz_r * cos_x_r;
    c_zs_r  <= b_z_r * sin_x_r;
    c_ys_r  <= b_yz_r * sin_x_r;
    c_zc_r  <= b_z_r * cos_x_r;
    c_xz_r  <= b_xz_r;
    c_sat_r <= b_sat_r;
  end

  // ---------------- stage d: X rotation round/clamp ----------------
  logic               d_vld_r, d_sat_r;
  logic signed [31:0] d_xz_r, d_yr_r, d_zr_r;
  logic signed [50:0] d_sy, d_sz;
  logic [32:0]        d_ry, d_rz;

  always_comb begin
    d_sy = 51'(c_yc_r) - 51'(c_zs_r);
    d_sz = 51'(c_ys_r) + 51'(c_zc_r);
    d_ry = rnd_sat(64'(d_sy));
    d_rz = rnd_sat(64'(d_sz));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else        d_vld_r <= c_vld_r;
  end
  always_ff @(posedge clk) begin
    d_xz_r  <= c_xz_r;
    d_yr_r  <= d_ry[31:0];
    d_zr_r  <= d_rz[31:0];
    d_sat_r <= c_sat_r | d_ry[32] | d_rz[32];
  end

  // ---------------- stage e: depth and projection products ----------------
  logic               e_vld_r, e_sat_r;
  logic signed [31:0] e_depth_r;
  logic signed [57:0] e_px_r, e_py_r;
  logic signed [32:0] e_dsum;
  logic [32:0]        e_dsat;

  always_comb begin
    e_dsum = 33'(d_zr_r) + THREE_Q;
    e_dsat = sat32(64'(e_dsum));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) e_vld_r <= 1'b0;
    else        e_vld_r <= d_vld_r;
  end
  always_ff @(posedge clk) begin
    e_depth_r <= e_dsat[31:0];
    e_px_r    <= d_xz_r * $signed({1'b0, proj_x_r});
    e_py_r    <= d_yr_r * $signed({1'b0, proj_y_r});
    e_sat_r   <= d_sat_r | e_dsat[32];
  end

  // ---------------- stage f: divider setup, zero-depth bypass ----------------
  logic               f_dz;
  logic [31:0]        f_dmag;
  logic [57:0]        f_nx, f_ny;
  logic [32:0]        f_bx, f_by;

  logic               dv_vld_r [DIV_STAGES+1];
  logic               dv_dz_r  [DIV_STAGES+1];
  logic               dv_sat_r [DIV_STAGES+1];
  logic [31:0]        dv_dmag_r[DIV_STAGES+1];
  logic [31:0]        dv_rx_r  [DIV_STAGES+1];
  logic [31:0]        dv_qx_r  [DIV_STAGES+1];
  logic [31:0]        dv_ry_r  [DIV_STAGES+1];
  logic [31:0]        dv_qy_r  [DIV_STAGES+1];
  logic               dv_ovx_r [DIV_STAGES+1];
  logic               dv_ovy_r [DIV_STAGES+1];
  logic               dv_ngx_r [DIV_STAGES+1];
  logic               dv_ngy_r [DIV_STAGES+1];
  logic [31:0]        dv_bx_r  [DIV_STAGES+1];
  logic [31:0]        dv_by_r  [DIV_STAGES+1];

  always_comb begin
    f_dz   = (e_depth_r == '0);
    f_dmag = e_depth_r[31] ? 32'(-e_depth_r) : 32'(e_depth_r);
    f_nx   = e_px_r[57] ? 58'(-e_px_r) : 58'(e_px_r);
    f_ny   = e_py_r[57] ? 58'(-e_py_r) : 58'(e_py_r);
    f_bx   = rnd_sat(64'(e_px_r));
    f_by   = rnd_sat(64'(e_py_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else        dv_vld_r[0] <= e_vld_r;
  end
  always_ff @(posedge clk) begin
    dv_dz_r[0]   <= f_dz;
    // bypass clamps only count when the divide is skipped
    dv_sat_r[0]  <= e_sat_r | (f_dz & (f_bx[32] | f_by[32]));
    dv_dmag_r[0] <= f_dmag;
    // quotient >= 2^32 exactly when the high part already reaches the divisor
    dv_ovx_r[0]  <= {7'd0, f_nx[56:32]} >= f_dmag;
    dv_ovy_r[0]  <= {7'd0, f_ny[56:32]} >= f_dmag;
    dv_rx_r[0]   <= {7'd0, f_nx[56:32]};
    dv_ry_r[0]   <= {7'd0, f_ny[56:32]};
    dv_qx_r[0]   <= f_nx[31:0];
    dv_qy_r[0]   <= f_ny[31:0];
    dv_ngx_r[0]  <= e_px_r[57] ^ e_depth_r[31];
    dv_ngy_r[0]  <= e_py_r[57] ^ e_depth_r[31];
    dv_bx_r[0]   <= f_bx[31:0];
    dv_by_r[0]   <= f_by[31:0];
  end

  // ---------------- divider: one restoring step per stage ----------------
  // q registers shift dividend bits out at the top and quotient bits in at the bottom
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [32:0] tx, ty;
    logic        gex, gey;

    always_comb begin
      tx  = {dv_rx_r[k], dv_qx_r[k][31]};
      ty  = {dv_ry_r[k], dv_qy_r[k][31]};
      gex = tx >= {1'b0, dv_dmag_r[k]};
      gey = ty >= {1'b0, dv_dmag_r[k]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[k+1] <= 1'b0;
      else        dv_vld_r[k+1] <= dv_vld_r[k];
    end
    always_ff @(posedge clk) begin
      dv_rx_r[k+1]   <= gex ? 32'(tx - {1'b0, dv_dmag_r[k]}) : tx[31:0];
      dv_ry_r[k+1]   <= gey ? 32'(ty - {1'b0, dv_dmag_r[k]}) : ty[31:0];
      dv_qx_r[k+1]   <= {dv_qx_r[k][30:0], gex};
      dv_qy_r[k+1]   <= {dv_qy_r[k][30:0], gey};
      dv_dz_r[k+1]   <= dv_dz_r[k];
      dv_sat_r[k+1]  <= dv_sat_r[k];
      dv_dmag_r[k+1] <= dv_dmag_r[k];
      dv_ovx_r[k+1]  <= dv_ovx_r[k];
      dv_ovy_r[k+1]  <= dv_ovy_r[k];
      dv_ngx_r[k+1]  <= dv_ngx_r[k];
      dv_ngy_r[k+1]  <= dv_ngy_r[k];
      dv_bx_r[k+1]   <= dv_bx_r[k];
      dv_by_r[k+1]   <= dv_by_r[k];
    end
  end

  // ---------------- stage g: signed quotient, clamp ----------------
  logic               g_vld_r, g_dz_r, g_sat_r;
  logic signed [31:0] g_px_r, g_py_r;
  logic signed [32:0] g_qx, g_qy;
  logic [32:0]        g_cx, g_cy;
  logic [31:0]        g_px, g_py;
  logic               g_fx, g_fy;

  always_comb begin
    g_qx = dv_ngx_r[DIV_STAGES] ? -$signed({1'b0, dv_qx_r[DIV_STAGES]})
                                :  $signed({1'b0, dv_qx_r[DIV_STAGES]});
    g_qy = dv_ngy_r[DIV_STAGES] ? -$signed({1'b0, dv_qy_r[DIV_STAGES]})
                                :  $signed({1'b0, dv_qy_r[DIV_STAGES]});
    g_cx = sat32(64'(g_qx));
    g_cy = sat32(64'(g_qy));
    if (dv_dz_r[DIV_STAGES]) begin
      g_px = dv_bx_r[DIV_STAGES];
      g_fx = 1'b0;
    end else if (dv_ovx_r[DIV_STAGES]) begin
      g_px = dv_ngx_r[DIV_STAGES] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      g_fx = 1'b1;
    end else begin
      g_px = g_cx[31:0];
      g_fx = g_cx[32];
    end
    if (dv_dz_r[DIV_STAGES]) begin
      g_py = dv_by_r[DIV_STAGES];
      g_fy = 1'b0;
    end else if (dv_ovy_r[DIV_STAGES]) begin
      g_py = dv_ngy_r[DIV_STAGES] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      g_fy = 1'b1;
    end else begin
      g_py = g_cy[31:0];
      g_fy = g_cy[32];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) g_vld_r <= 1'b0;
    else        g_vld_r <= dv_vld_r[DIV_STAGES];
  end
  always_ff @(posedge clk) begin
    g_px_r  <= g_px;
    g_py_r  <= g_py;
    g_dz_r  <= dv_dz_r[DIV_STAGES];
    g_sat_r <= dv_sat_r[DIV_STAGES] | g_fx | g_fy;
  end

  // ---------------- stage h: (p + 1.0) * size ----------------
  logic               h_vld_r, h_dz_r, h_sat_r;
  logic signed [46:0] h_vx_r, h_vy_r;
  logic signed [32:0] h_ox, h_oy;

  always_comb begin
    h_ox = 33'(g_px_r) + ONE_Q;
    h_oy = 33'(g_py_r) + ONE_Q;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) h_vld_r <= 1'b0;
    else        h_vld_r <= g_vld_r;
  end
  always_ff @(posedge clk) begin
    h_vx_r  <= h_ox * $signed({1'b0, scr_w_r});
    h_vy_r  <= h_oy * $signed({1'b0, scr_h_r});
    h_dz_r  <= g_dz_r;
    h_sat_r <= g_sat_r;
  end

  // ---------------- stage i: halve (floor), clamp, output register ----------------
  logic [32:0] i_sx, i_sy;
  logic        out_vld_r;
  out_beat_t   out_beat_r;

  always_comb begin
    i_sx = sat32(64'(h_vx_r >>> 1));
    i_sy = sat32(64'(h_vy_r >>> 1));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= h_vld_r;
  end
  always_ff @(posedge clk) begin
    out_beat_r.screen_x   <= i_sx[31:0];
    out_beat_r.screen_y   <= i_sy[31:0];
    out_beat_r.depth_zero <= h_dz_r;
    out_beat_r.saturated  <= h_sat_r | i_sx[32] | i_sy[32];
  end

  assign out_strobe = out_vld_r;
  assign out_beat   = out_beat_r;

  // ---------------- assertions ----------------
  // every result beat traces back to an earlier accepted start beat
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> $past(in_accept, 41))
    else $error("result beat without matching start beat");

  // a finished divide without zero depth or X overflow leaves an X remainder below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld_r[DIV_STAGES] && !dv_dz_r[DIV_STAGES] && !dv_ovx_r[DIV_STAGES])
      |-> (dv_rx_r[DIV_STAGES] < dv_dmag_r[DIV_STAGES]))
    else $error("divider remainder not below divisor");

  // depth_zero is only set together with a zero divisor
  a_dz_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld_r[0] && dv_dz_r[0]) |-> (dv_dmag_r[0] == '0))
    else $error("depth_zero set with nonzero divisor");

endmodule
`default_nettype wire
